>>> sv/alu16_pkg.sv
// alu16_pkg: shared types and constants for the 16-bit alu with status flags
// operation codes, flag record and operand masks; no dependencies

package alu16_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned ACT_W  = 4;

  localparam logic [DATA_W-1:0] MASK_BYTE = 16'h00ff;
  localparam logic [DATA_W-1:0] MASK_HIGH = 16'hff00;
  localparam logic [DATA_W-1:0] SIGN_BYTE = 16'h0080;
  localparam logic [DATA_W-1:0] SIGN_WORD = 16'h8000;

  typedef enum logic [ACT_W-1:0] {
    ACT_MOV  = 4'd0,
    ACT_ADD  = 4'd1,
    ACT_ADDC = 4'd2,
    ACT_SUB  = 4'd3,
    ACT_SUBC = 4'd4,
    ACT_CMP  = 4'd5,
    ACT_RRC  = 4'd6,
    ACT_SWPB = 4'd7,
    ACT_RRA  = 4'd8,
    ACT_SXT  = 4'd9
  } action_t;

  typedef struct packed {
    logic v;
    logic n;
    logic z;
    logic c;
  } flags_t;

  localparam flags_t FLAGS_CLEAR = '{v: 1'b0, n: 1'b0, z: 1'b0, c: 1'b0};

endpackage

>>> sv/alu16_cmd_if.sv
// alu16_cmd_if: valid/ready channel carrying one alu operation
// depends on alu16_pkg for widths

interface alu16_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [alu16_pkg::ACT_W-1:0]         action;
  logic                                byte_mode;
  logic [alu16_pkg::DATA_W-1:0]        source_value;
  logic [alu16_pkg::DATA_W-1:0]        dest_value;

  modport source (output valid, action, byte_mode, source_value, dest_value, input ready);
  modport sink   (input valid, action, byte_mode, source_value, dest_value, output ready);
endinterface

>>> sv/alu16_rsp_if.sv
// alu16_rsp_if: valid/ready channel carrying one alu result and its flags
// depends on alu16_pkg for widths

interface alu16_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [alu16_pkg::DATA_W-1:0]        result;
  logic                                write_back;
  logic                                carry_flag;
  logic                                zero_flag;
  logic                                negative_flag;
  logic                                overflow_flag;

  modport source (output valid, result, write_back, carry_flag, zero_flag, negative_flag,
                  overflow_flag, input ready);
  modport sink   (input valid, result, write_back, carry_flag, zero_flag, negative_flag,
                  overflow_flag, output ready);
endinterface

>>> sv/alu16_exec.sv
// alu16_exec: combinational datapath, one operation against the current flags
// depends on alu16_pkg (action_t, flags_t, masks)

module alu16_exec (
  input  alu16_pkg::action_t              action,
  input  logic                            byte_mode,
  input  logic [alu16_pkg::DATA_W-1:0]    source_value,
  input  logic [alu16_pkg::DATA_W-1:0]    dest_value,
  input  alu16_pkg::flags_t               flags,
  output logic [alu16_pkg::DATA_W-1:0]    result,
  output logic                            write_back,
  output alu16_pkg::flags_t               flags_next
);

  logic [alu16_pkg::DATA_W-1:0] mask;
  logic [alu16_pkg::DATA_W-1:0] sign_bit;
  logic [alu16_pkg::DATA_W-1:0] src;
  logic [alu16_pkg::DATA_W-1:0] dst;
  logic [alu16_pkg::DATA_W-1:0] add_a;
  logic                         add_cin;
  logic [alu16_pkg::DATA_W:0]   sum;
  logic [alu16_pkg::DATA_W-1:0] sum_res;
  logic                         sum_carry;
  logic                         sum_ovf;
  logic [alu16_pkg::DATA_W-1:0] shr_res;
  logic [alu16_pkg::DATA_W-1:0] rrc_res;
  logic [alu16_pkg::DATA_W-1:0] rra_res;
  logic [alu16_pkg::DATA_W-1:0] swp_res;
  logic [alu16_pkg::DATA_W-1:0] sxt_res;
  logic                         is_sub;

  assign mask     = byte_mode ? alu16_pkg::MASK_BYTE : ~alu16_pkg::MASK_BYTE | alu16_pkg::MASK_BYTE;
  assign sign_bit = byte_mode ? alu16_pkg::SIGN_BYTE : alu16_pkg::SIGN_WORD;
  assign src      = source_value & mask;
  assign dst      = dest_value & mask;

  assign is_sub = (action == alu16_pkg::ACT_SUB) || (action == alu16_pkg::ACT_SUBC) ||
                  (action == alu16_pkg::ACT_CMP);

  always_comb begin
    add_a = is_sub ? (~src & mask) : src;
    case (action)
      alu16_pkg::ACT_ADDC, alu16_pkg::ACT_SUBC: add_cin = flags.c;
      alu16_pkg::ACT_SUB, alu16_pkg::ACT_CMP:   add_cin = 1'b1;
      default:                                  add_cin = 1'b0;
    endcase
  end

  assign sum = {1'b0, add_a} + {1'b0, dst} + {{alu16_pkg::DATA_W{1'b0}}, add_cin};
  assign sum_res = sum[alu16_pkg::DATA_W-1:0] & mask;
  // carry out of the operating width
  assign sum_carry = byte_mode ? sum[8] : sum[alu16_pkg::DATA_W];
  assign sum_ovf = (((add_a & sign_bit) == (dst & sign_bit)) &&
                    (((sum_res ^ dst) & sign_bit) != '0));

  assign shr_res = src >> 1;
  assign rrc_res = shr_res | (flags.c ? sign_bit : '0);
  assign rra_res = shr_res | (src & sign_bit);
  assign swp_res = {source_value[7:0], source_value[15:8]} & mask;
  assign sxt_res = (source_value[7] ? (alu16_pkg::MASK_HIGH | {8'h00, source_value[7:0]})
                                    : {8'h00, source_value[7:0]}) & mask;

  always_comb begin
    result     = '0;
    write_back = 1'b1;
    flags_next = flags;
    case (action)
      alu16_pkg::ACT_MOV: begin
        result = src;
      end
      alu16_pkg::ACT_ADD, alu16_pkg::ACT_ADDC, alu16_pkg::ACT_SUB,
      alu16_pkg::ACT_SUBC, alu16_pkg::ACT_CMP: begin
        result       = sum_res;
        flags_next.c = sum_carry;
        flags_next.z = (sum_res == '0);
        flags_next.n = ((sum_res & sign_bit) != '0);
        flags_next.v = sum_ovf;
        if (action == alu16_pkg::ACT_CMP) begin
          result     = '0;
          write_back = 1'b0;
        end
      end
      alu16_pkg::ACT_RRC: begin
        result       = rrc_res;
        flags_next.c = src[0];
        flags_next.z = (rrc_res == '0);
        flags_next.n = ((rrc_res & sign_bit) != '0);
        flags_next.v = 1'b0;
      end
      alu16_pkg::ACT_SWPB: begin
        result = swp_res;
      end
      alu16_pkg::ACT_RRA: begin
        result       = rra_res;
        flags_next.c = src[0];
        flags_next.z = (rra_res == '0);
        flags_next.n = ((rra_res & sign_bit) != '0);
        flags_next.v = 1'b0;
      end
      alu16_pkg::ACT_SXT: begin
        result       = sxt_res;
        flags_next.c = (sxt_res != '0);
        flags_next.z = (sxt_res == '0);
        flags_next.n = source_value[7];
        flags_next.v = 1'b0;
      end
      default: begin
        // unused codes: nothing written, flags kept
        result     = '0;
        write_back = 1'b0;
      end
    endcase
  end

endmodule

>>> sv/sixteen_bit_alu_with_status_flags_core.sv
// sixteen_bit_alu_with_status_flags_core: execute stage of a small 16-bit cpu
// input register, alu16_exec datapath, result register and flag register
// depends on alu16_pkg, alu16_cmd_if, alu16_rsp_if, alu16_exec
//
// usage:
//   cmd carries one operation per transfer: action, byte_mode, source_value,
//   dest_value. rsp carries one result per operation, in order: result,
//   write_back and the carry, zero, negative and overflow flags after it.
//   an operation taken from cmd waits in the input register, then passes
//   through alu16_exec into the result register and is presented on rsp.
//   one operation per cycle is sustained while rsp does not stall; carry
//   in comes from the flag register, which is written in the same cycle an
//   operation moves from the input register to the result register, so
//   back to back operations chain their carries.
//   when rsp stalls, the result register holds and the input register
//   still takes one more operation; cmd.ready drops only when both are full.
//   reset (rst, synchronous) empties both registers and clears all flags.

module sixteen_bit_alu_with_status_flags_core (
  input  logic        clk,
  input  logic        rst,
  alu16_cmd_if.sink   cmd,
  alu16_rsp_if.source rsp
);

  logic                                 s1_valid;
  logic [alu16_pkg::ACT_W-1:0]          s1_action;
  logic                                 s1_byte;
  logic [alu16_pkg::DATA_W-1:0]         s1_src;
  logic [alu16_pkg::DATA_W-1:0]         s1_dst;

  logic                                 out_valid;
  logic [alu16_pkg::DATA_W-1:0]         out_result;
  logic                                 out_wb;
  alu16_pkg::flags_t                    flags;

  logic                                 s2_load;
  logic                                 s1_adv;
  logic [alu16_pkg::DATA_W-1:0]         exec_result;
  logic                                 exec_wb;
  alu16_pkg::flags_t                    flags_next;

  assign s2_load   = !out_valid || rsp.ready;
  assign s1_adv    = s1_valid && s2_load;
  assign cmd.ready = !s1_valid || s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_action <= cmd.action;
      s1_byte   <= cmd.byte_mode;
      s1_src    <= cmd.source_value;
      s1_dst    <= cmd.dest_value;
    end
  end

  alu16_exec u_exec (
    .action       (alu16_pkg::action_t'(s1_action)),
    .byte_mode    (s1_byte),
    .source_value (s1_src),
    .dest_value   (s1_dst),
    .flags        (flags),
    .result       (exec_result),
    .write_back   (exec_wb),
    .flags_next   (flags_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      flags     <= alu16_pkg::FLAGS_CLEAR;
    end else begin
      if (s2_load) begin
        out_valid <= s1_valid;
      end
      if (s1_adv) begin
        flags <= flags_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_result <= exec_result;
      out_wb     <= exec_wb;
    end
  end

  // the flags shown with a result are the flag register once it is taken
  assign rsp.valid         = out_valid;
  assign rsp.result        = out_result;
  assign rsp.write_back    = out_wb;
  assign rsp.carry_flag    = flags.c;
  assign rsp.zero_flag     = flags.z;
  assign rsp.negative_flag = flags.n;
  assign rsp.overflow_flag = flags.v;

  // a compare never produces a write-back
  a_cmp_no_wb: assert property (@(posedge clk) disable iff (rst)
    s1_adv && (s1_action == alu16_pkg::ACT_CMP) |=> rsp.valid && !rsp.write_back)
    else $error("compare produced a write-back");

  // move and swap leave the flags alone
  a_mov_keeps_flags: assert property (@(posedge clk) disable iff (rst)
    s1_adv && ((s1_action == alu16_pkg::ACT_MOV) || (s1_action == alu16_pkg::ACT_SWPB))
    |=> flags == $past(flags))
    else $error("flags changed by move or swap");

  // flags change only when an operation reaches the result register
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> $stable(flags))
    else $error("flags changed without an operation");

  // reset empties the pipeline and clears the flags
  a_reset_clear: assert property (@(posedge clk)
    !rst && $past(rst) |-> !rsp.valid && (flags == alu16_pkg::FLAGS_CLEAR) && cmd.ready)
    else $error("state not cleared by reset");

endmodule
